### src/mqps_pkg.sv
// Shared types and constants for the multi-queue priority selector.
// Used by the top level and the testbench; depends on nothing else.
package mqps_pkg;

  // Default sizes of the queue set.
  localparam int NUM_TASKS_DEF  = 8;
  localparam int SLOT_DEPTH_DEF = 16;

  // One stored entry: {priority[55:48], handle[47:16], size[15:0]}.
  localparam int PRIO_W   = 8;
  localparam int HANDLE_W = 32;
  localparam int SIZE_W   = 16;
  localparam int ENTRY_W  = PRIO_W + HANDLE_W + SIZE_W;

  // Field widths on the ports.
  localparam int TASK_IN_W  = 3;
  localparam int STATUS_W   = 2;
  localparam int ACTIVE_W   = 4;
  localparam int LIMIT_W    = 5;
  localparam int CFG_DATA_W = 5;
  localparam int IN_DATA_W  = 64;
  localparam int OUT_DATA_W = 64;

  // Operation codes carried on in_tuser.
  localparam logic OP_ENQUEUE = 1'b0;
  localparam logic OP_DEQUEUE = 1'b1;

  // Result status codes.
  localparam logic [STATUS_W-1:0] STAT_OK    = 2'd0;
  localparam logic [STATUS_W-1:0] STAT_RANGE = 2'd1;
  localparam logic [STATUS_W-1:0] STAT_FULL  = 2'd2;
  localparam logic [STATUS_W-1:0] STAT_EMPTY = 2'd3;

  // Configuration register indexes.
  localparam logic CFG_ACTIVE = 1'b0;
  localparam logic CFG_LIMIT  = 1'b1;

  // Register reset values.
  localparam logic [ACTIVE_W-1:0] ACTIVE_RST = 4'd8;
  localparam logic [LIMIT_W-1:0]  LIMIT_RST  = 5'd16;

  // Sequencer states, one-hot.
  typedef enum logic [4:0] {
    ST_IDLE = 5'b00001,
    ST_OP   = 5'b00010,
    ST_DEQ  = 5'b00100,
    ST_SCAN = 5'b01000,
    ST_DONE = 5'b10000
  } state_t;

endpackage

### src/mqps_ram.sv
// Generic single-write, single-read RAM with registered read data.
// Holds the queue entries of the selector; depends on nothing else.
module mqps_ram #(
  parameter int WIDTH = 56,
  parameter int DEPTH = 128
) (
  input  logic                                  clk,
  input  logic                                  we,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                      wdata,
  input  logic                                  re,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                      rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  // Write port and registered read port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

### src/multi_queue_priority_select.sv
// Multi-queue strict priority selector: one FIFO of entries per task.
// Depends on mqps_pkg and mqps_ram.
//
// Usage:
//   The input channel (in_*) carries one operation per transaction: enqueue
//   an entry to a task or dequeue the head of a task (in_tuser). The result
//   channel (out_*) returns exactly one transaction per input with the
//   status, the dequeued entry (zeros otherwise) and the task whose head
//   entry holds the strictly highest priority, lowest index on a tie.
//   The configuration port writes active_tasks (index 0) and queue_limit
//   (index 1); write it only while the block is idle.
// Timing:
//   One operation is handled at a time. After acceptance ST_OP updates the
//   queue (a successful dequeue then reads the entry RAM, captured in
//   ST_DEQ), then one shared comparator in ST_SCAN walks the active task
//   heads, one task per cycle through the RAM read port, plus a final
//   compare step. ST_DONE then loads the result into the output register
//   and the block returns to ST_IDLE; only there is the next item taken.
// Reset and stall:
//   Reset empties every queue and restores both registers; RAM contents are
//   not cleared and never read before written. A stalled receiver holds the
//   result in the output register; the block waits before the next item.
module multi_queue_priority_select #(
  parameter int NUM_TASKS  = mqps_pkg::NUM_TASKS_DEF,
  parameter int SLOT_DEPTH = mqps_pkg::SLOT_DEPTH_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  // Input channel.
  input  logic                              in_tvalid,
  output logic                              in_tready,
  // tdata: task_index[2:0], priority_req[10:3], payload_handle[42:11],
  //        payload_size[58:43], zero fill [63:59].
  input  logic [mqps_pkg::IN_DATA_W-1:0]    in_tdata,
  // tuser: operation[0].
  input  logic                              in_tuser,
  // Result channel.
  output logic                              out_tvalid,
  input  logic                              out_tready,
  // tdata: status[1:0], out_priority[9:2], out_handle[41:10],
  //        out_size[57:42], best_valid[58], best_task[61:59], zero [63:62].
  output logic [mqps_pkg::OUT_DATA_W-1:0]   out_tdata,
  // Configuration port.
  input  logic                              cfg_we,
  input  logic                              cfg_index,
  input  logic [mqps_pkg::CFG_DATA_W-1:0]   cfg_wdata
);

  import mqps_pkg::*;

  localparam int TASK_W = (NUM_TASKS > 1) ? $clog2(NUM_TASKS) : 1;
  localparam int PTR_W  = (SLOT_DEPTH > 1) ? $clog2(SLOT_DEPTH) : 1;
  localparam int CNT_W  = $clog2(SLOT_DEPTH + 1);
  localparam int ACT_W  = ($clog2(NUM_TASKS + 1) > ACTIVE_W) ? $clog2(NUM_TASKS + 1) : ACTIVE_W;
  localparam int LW     = (CNT_W > LIMIT_W) ? CNT_W : LIMIT_W;
  localparam int SW     = ((PTR_W > CNT_W) ? PTR_W : CNT_W) + 1;
  localparam int RAM_D  = NUM_TASKS * SLOT_DEPTH;
  localparam int ADDR_W = (RAM_D > 1) ? $clog2(RAM_D) : 1;

  // Sequencer and captured operation.
  state_t                 state_r, state_nxt;
  logic                   op_r, op_nxt;
  logic [TASK_IN_W-1:0]   task_r, task_nxt;
  logic [PRIO_W-1:0]      prio_r, prio_nxt;
  logic [HANDLE_W-1:0]    handle_r, handle_nxt;
  logic [SIZE_W-1:0]      size_r, size_nxt;

  // Result fields under construction.
  logic [STATUS_W-1:0]    status_r, status_nxt;
  logic [PRIO_W-1:0]      oprio_r, oprio_nxt;
  logic [HANDLE_W-1:0]    ohandle_r, ohandle_nxt;
  logic [SIZE_W-1:0]      osize_r, osize_nxt;

  // Selection scan state.
  logic [ACT_W-1:0]       scan_r, scan_nxt;
  logic                   pend_r, pend_nxt;
  logic [TASK_W-1:0]      pend_idx_r, pend_idx_nxt;
  logic                   found_r, found_nxt;
  logic [TASK_W-1:0]      best_r, best_nxt;
  logic [PRIO_W-1:0]      bestp_r, bestp_nxt;

  // Output register.
  logic                   out_valid_r, out_valid_nxt;
  logic [OUT_DATA_W-1:0]  out_data_r, out_data_nxt;

  // Configuration registers.
  logic [ACTIVE_W-1:0]    act_r, act_nxt;
  logic [LIMIT_W-1:0]     lim_r, lim_nxt;

  // Per-task queue pointers.
  logic [PTR_W-1:0]       head_r [NUM_TASKS];
  logic [CNT_W-1:0]       cnt_r  [NUM_TASKS];
  logic                   head_we, cnt_we;
  logic [PTR_W-1:0]       head_wval;
  logic [CNT_W-1:0]       cnt_wval;

  // Shared datapath.
  logic [ACT_W-1:0]       active_eff, task_ext;
  logic [LW-1:0]          lim_eff;
  logic                   in_range;
  logic [TASK_W-1:0]      sel_idx;
  logic [PTR_W-1:0]       cur_head;
  logic [CNT_W-1:0]       cur_cnt;
  logic [CNT_W-1:0]       offset;
  logic [SW-1:0]          pos_sum, pos;
  logic [ADDR_W-1:0]      addr;
  logic                   ram_we, ram_re;
  logic [ENTRY_W-1:0]     ram_wdata, ram_rdata;
  logic [PRIO_W-1:0]      rd_prio;
  logic [TASK_IN_W-1:0]   best_task_out;

  // Effective configuration, saturated to the built sizes.
  always_comb begin
    active_eff = (ACT_W'(act_r) > ACT_W'(NUM_TASKS)) ? ACT_W'(NUM_TASKS) : ACT_W'(act_r);
    lim_eff    = (LW'(lim_r) > LW'(SLOT_DEPTH)) ? LW'(SLOT_DEPTH) : LW'(lim_r);
    task_ext   = ACT_W'(task_r);
    in_range   = (task_ext < active_eff);
  end

  // One task is addressed at a time: the operation's task, then the scan index.
  assign sel_idx  = (state_r == ST_OP) ? task_ext[TASK_W-1:0] : scan_r[TASK_W-1:0];
  assign cur_head = head_r[sel_idx];
  assign cur_cnt  = cnt_r[sel_idx];

  // Slot address: task base plus head offset, wrapped once around the queue.
  always_comb begin
    offset  = ((state_r == ST_OP) && (op_r == OP_ENQUEUE)) ? cur_cnt : '0;
    pos_sum = SW'(cur_head) + SW'(offset);
    pos     = (pos_sum >= SW'(SLOT_DEPTH)) ? (pos_sum - SW'(SLOT_DEPTH)) : pos_sum;
    addr    = ADDR_W'(sel_idx) * ADDR_W'(SLOT_DEPTH) + ADDR_W'(pos);
  end

  assign ram_wdata = {prio_r, handle_r, size_r};
  assign rd_prio   = ram_rdata[ENTRY_W-1 -: PRIO_W];

  mqps_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (RAM_D)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (addr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (addr),
    .rdata (ram_rdata)
  );

  assign best_task_out = found_r ? TASK_IN_W'(best_r) : '0;

  // Sequencer and datapath next values.
  always_comb begin
    state_nxt     = state_r;
    op_nxt        = op_r;
    task_nxt      = task_r;
    prio_nxt      = prio_r;
    handle_nxt    = handle_r;
    size_nxt      = size_r;
    status_nxt    = status_r;
    oprio_nxt     = oprio_r;
    ohandle_nxt   = ohandle_r;
    osize_nxt     = osize_r;
    scan_nxt      = scan_r;
    pend_nxt      = pend_r;
    pend_idx_nxt  = pend_idx_r;
    found_nxt     = found_r;
    best_nxt      = best_r;
    bestp_nxt     = bestp_r;
    out_valid_nxt = out_valid_r;
    out_data_nxt  = out_data_r;
    act_nxt       = act_r;
    lim_nxt       = lim_r;
    head_we       = 1'b0;
    cnt_we        = 1'b0;
    head_wval     = cur_head;
    cnt_wval      = cur_cnt;
    ram_we        = 1'b0;
    ram_re        = 1'b0;

    // The receiver takes the waiting result.
    if (out_valid_r && out_tready) begin
      out_valid_nxt = 1'b0;
    end

    // Configuration writes.
    if (cfg_we) begin
      unique case (cfg_index)
        CFG_ACTIVE: act_nxt = cfg_wdata[ACTIVE_W-1:0];
        CFG_LIMIT:  lim_nxt = cfg_wdata[LIMIT_W-1:0];
        default:    ;
      endcase
    end

    unique case (state_r)
      ST_IDLE: begin
        if (in_tvalid) begin
          op_nxt     = in_tuser;
          task_nxt   = in_tdata[2:0];
          prio_nxt   = in_tdata[10:3];
          handle_nxt = in_tdata[42:11];
          size_nxt   = in_tdata[58:43];
          state_nxt  = ST_OP;
        end
      end

      // Queue update for the addressed task.
      ST_OP: begin
        status_nxt  = STAT_OK;
        oprio_nxt   = '0;
        ohandle_nxt = '0;
        osize_nxt   = '0;
        scan_nxt    = '0;
        pend_nxt    = 1'b0;
        found_nxt   = 1'b0;
        state_nxt   = ST_SCAN;
        if (!in_range) begin
          status_nxt = STAT_RANGE;
        end else if (op_r == OP_ENQUEUE) begin
          if (LW'(cur_cnt) >= lim_eff) begin
            status_nxt = STAT_FULL;
          end else begin
            ram_we   = 1'b1;
            cnt_we   = 1'b1;
            cnt_wval = cur_cnt + 1'b1;
          end
        end else begin
          if (cur_cnt == '0) begin
            status_nxt = STAT_EMPTY;
          end else begin
            ram_re    = 1'b1;
            cnt_we    = 1'b1;
            cnt_wval  = cur_cnt - 1'b1;
            head_we   = 1'b1;
            head_wval = (PTR_W'(cur_head + 1'b1) == PTR_W'(SLOT_DEPTH) ||
                         SLOT_DEPTH == 1) ? '0 : PTR_W'(cur_head + 1'b1);
            state_nxt = ST_DEQ;
          end
        end
      end

      // Capture the dequeued entry from the RAM.
      ST_DEQ: begin
        oprio_nxt   = ram_rdata[ENTRY_W-1 -: PRIO_W];
        ohandle_nxt = ram_rdata[SIZE_W +: HANDLE_W];
        osize_nxt   = ram_rdata[SIZE_W-1:0];
        state_nxt   = ST_SCAN;
      end

      // Walk the active task heads: read one head, compare the previous one.
      ST_SCAN: begin
        if (pend_r && (!found_r || (rd_prio > bestp_r))) begin
          found_nxt = 1'b1;
          best_nxt  = pend_idx_r;
          bestp_nxt = rd_prio;
        end
        if (scan_r < active_eff) begin
          pend_nxt     = (cur_cnt != '0);
          pend_idx_nxt = sel_idx;
          ram_re       = (cur_cnt != '0);
          scan_nxt     = scan_r + 1'b1;
        end else begin
          pend_nxt  = 1'b0;
          state_nxt = ST_DONE;
        end
      end

      // Hand the result to the output register once it is free.
      ST_DONE: begin
        if (!out_valid_r || out_tready) begin
          out_valid_nxt = 1'b1;
          out_data_nxt  = {2'b00, best_task_out, found_r, osize_r, ohandle_r,
                           oprio_r, status_r};
          state_nxt     = ST_IDLE;
        end
      end

      default: state_nxt = ST_IDLE;
    endcase
  end

  assign in_tready  = (state_r == ST_IDLE);
  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

  // Control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
      pend_r      <= 1'b0;
      found_r     <= 1'b0;
      scan_r      <= '0;
      act_r       <= ACTIVE_RST;
      lim_r       <= LIMIT_RST;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      pend_r      <= pend_nxt;
      found_r     <= found_nxt;
      scan_r      <= scan_nxt;
      act_r       <= act_nxt;
      lim_r       <= lim_nxt;
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    op_r       <= op_nxt;
    task_r     <= task_nxt;
    prio_r     <= prio_nxt;
    handle_r   <= handle_nxt;
    size_r     <= size_nxt;
    status_r   <= status_nxt;
    oprio_r    <= oprio_nxt;
    ohandle_r  <= ohandle_nxt;
    osize_r    <= osize_nxt;
    pend_idx_r <= pend_idx_nxt;
    best_r     <= best_nxt;
    bestp_r    <= bestp_nxt;
    out_data_r <= out_data_nxt;
  end

  // Per-task head pointers and fill counts, one write per cycle.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < NUM_TASKS; i++) begin
        head_r[i] <= '0;
        cnt_r[i]  <= '0;
      end
    end else begin
      if (head_we) begin
        head_r[sel_idx] <= head_wval;
      end
      if (cnt_we) begin
        cnt_r[sel_idx] <= cnt_wval;
      end
    end
  end

endmodule

### verif/tb_multi_queue_priority_select.sv
`timescale 1ns / 100ps
// Self-checking testbench for multi_queue_priority_select, the per-task queue
// selector. Depends on mqps_pkg and the RTL; predicts each result on its own.
module tb_multi_queue_priority_select;
  import mqps_pkg::*;

  localparam int NTASK          = NUM_TASKS_DEF;
  localparam int QDEPTH         = SLOT_DEPTH_DEF;
  localparam int WATCHDOG_LIMIT = 3000;
  localparam int HOLD_CYCLES    = 80;
  localparam int NUM_PHASES     = 10;

  // One operation as it travels on the input channel.
  typedef struct {
    logic        op;
    logic [2:0]  qid;
    logic [7:0]  prio;
    logic [31:0] buf_handle;
    logic [15:0] nbytes;
  } sched_req_t;

  // One result as it travels on the result channel.
  typedef struct {
    logic [STATUS_W-1:0] status;
    logic [7:0]          prio;
    logic [31:0]         buf_handle;
    logic [15:0]         nbytes;
    logic                best_valid;
    logic [2:0]          best_qid;
  } sched_res_t;

  typedef enum {ROW_ITEM, ROW_CFG} row_kind_t;

  // One row of the directed table: an operation or a register write.
  typedef struct {
    row_kind_t         kind;
    sched_req_t        req;
    logic              typed;
    sched_res_t        res;
    logic              cfg_idx;
    logic [CFG_DATA_W-1:0] cfg_val;
  } dir_row_t;

  logic                  clk;
  logic                  rst_n;
  logic                  in_tvalid;
  logic                  in_tready;
  logic [IN_DATA_W-1:0]  in_tdata;
  logic                  in_tuser;
  logic                  out_tvalid;
  logic                  out_tready;
  logic [OUT_DATA_W-1:0] out_tdata;
  logic                  cfg_we;
  logic                  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_wdata;

  // Shadow of the queue set and the registers.
  logic [ENTRY_W-1:0]  entry_mem [NTASK][QDEPTH];
  int                  head_ptr [NTASK];
  int                  fill [NTASK];
  logic [ACTIVE_W-1:0] active_reg;
  logic [LIMIT_W-1:0]  limit_reg;

  sched_res_t pending_results[$];
  dir_row_t   dir_rows[$];
  int         fail_count;
  int         idle_cycles;
  bit         tx_fast;
  bit         long_hold;

  multi_queue_priority_select u_top (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata)
  );

  // Clock, 4 ns period.
  initial clk = 1'b0;
  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  function automatic int eff_active();
    return (active_reg > NTASK) ? NTASK : int'(active_reg);
  endfunction

  // Applies one operation to the shadow queues and returns the result it yields.
  function automatic sched_res_t apply_queue_op(sched_req_t r);
    sched_res_t         res;
    int                 n_act;
    int                 lim;
    logic [ENTRY_W-1:0] e;
    logic [7:0]         p;
    logic [7:0]         best_p;
    n_act = eff_active();
    lim = (limit_reg > QDEPTH) ? QDEPTH : int'(limit_reg);
    res.status = STAT_OK;
    res.prio = '0;
    res.buf_handle = '0;
    res.nbytes = '0;
    res.best_valid = 1'b0;
    res.best_qid = '0;
    best_p = '0;
    if (r.qid >= n_act) begin
      res.status = STAT_RANGE;
    end else if (r.op == OP_ENQUEUE) begin
      if (fill[r.qid] >= lim) begin
        res.status = STAT_FULL;
      end else begin
        entry_mem[r.qid][(head_ptr[r.qid] + fill[r.qid]) % QDEPTH] =
          {r.prio, r.buf_handle, r.nbytes};
        fill[r.qid]++;
      end
    end else begin
      if (fill[r.qid] == 0) begin
        res.status = STAT_EMPTY;
      end else begin
        e = entry_mem[r.qid][head_ptr[r.qid]];
        res.prio = e[55:48];
        res.buf_handle = e[47:16];
        res.nbytes = e[15:0];
        head_ptr[r.qid] = (head_ptr[r.qid] + 1) % QDEPTH;
        fill[r.qid]--;
      end
    end
    // Strictly higher priority wins, so the lowest index keeps a tie.
    for (int q = 0; q < n_act; q++) begin
      if (fill[q] != 0) begin
        p = entry_mem[q][head_ptr[q]][55:48];
        if (!res.best_valid || p > best_p) begin
          res.best_valid = 1'b1;
          res.best_qid = q[2:0];
          best_p = p;
        end
      end
    end
    return res;
  endfunction

  function automatic sched_req_t make_req(logic op, logic [2:0] qid, logic [7:0] prio,
                                          logic [31:0] hdl, logic [15:0] nbytes);
    sched_req_t r;
    r.op = op;
    r.qid = qid;
    r.prio = prio;
    r.buf_handle = hdl;
    r.nbytes = nbytes;
    return r;
  endfunction

  // Directed rows whose result the predictor works out.
  function automatic void add_item(logic op, logic [2:0] qid, logic [7:0] prio,
                                   logic [31:0] hdl, logic [15:0] nbytes);
    dir_row_t row;
    row.kind = ROW_ITEM;
    row.req = make_req(op, qid, prio, hdl, nbytes);
    row.typed = 1'b0;
    row.cfg_idx = CFG_ACTIVE;
    row.cfg_val = '0;
    dir_rows.push_back(row);
  endfunction

  // Directed rows with a result known up front; no entry comes out of them.
  function automatic void add_typed(logic op, logic [2:0] qid, logic [7:0] prio,
                                    logic [31:0] hdl, logic [15:0] nbytes,
                                    logic [STATUS_W-1:0] status, logic bv,
                                    logic [2:0] bq);
    dir_row_t row;
    row.kind = ROW_ITEM;
    row.req = make_req(op, qid, prio, hdl, nbytes);
    row.typed = 1'b1;
    row.res.status = status;
    row.res.prio = '0;
    row.res.buf_handle = '0;
    row.res.nbytes = '0;
    row.res.best_valid = bv;
    row.res.best_qid = bq;
    row.cfg_idx = CFG_ACTIVE;
    row.cfg_val = '0;
    dir_rows.push_back(row);
  endfunction

  function automatic void add_cfg(logic idx, logic [CFG_DATA_W-1:0] val);
    dir_row_t row;
    row.kind = ROW_CFG;
    row.typed = 1'b0;
    row.cfg_idx = idx;
    row.cfg_val = val;
    dir_rows.push_back(row);
  endfunction

  function automatic void check_field(string name, logic [31:0] want, logic [31:0] got);
    if (want !== got) begin
      $error("%s mismatch: expected 0x%0h, got 0x%0h", name, want, got);
      fail_count++;
    end
  endfunction

  // Offers one operation after a random gap and records its expected result.
  task automatic send_req(sched_req_t r, logic typed, sched_res_t typed_res);
    int         gap;
    sched_res_t pred;
    gap = tx_fast ? 0 : $urandom_range(0, 19);
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata <= {5'b0, r.nbytes, r.buf_handle, r.prio, r.qid};
    in_tuser <= r.op;
    do @(posedge clk); while (!in_tready);
    pred = apply_queue_op(r);
    pending_results.push_back(typed ? typed_res : pred);
  endtask

  // Stops offering and waits until every expected result has come back.
  task automatic drain();
    in_tvalid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(logic idx, logic [CFG_DATA_W-1:0] val);
    cfg_index <= idx;
    cfg_wdata <= val;
    cfg_we <= 1'b1;
    @(posedge clk);
    cfg_we <= 1'b0;
    if (idx == CFG_ACTIVE) active_reg = val[ACTIVE_W-1:0];
    else limit_reg = val[LIMIT_W-1:0];
    @(posedge clk);
  endtask

  // Random operations in chunks, each chunk with its own mix of enqueues,
  // task focus, priority spread and sender gaps.
  task automatic run_phase(int n_items, bit do_hold, bit do_pause);
    int         chunk_left;
    int         enq_bias;
    bit         focus;
    bit         tie_mode;
    int         focus_qid;
    int         n_act;
    sched_req_t r;
    sched_res_t unused;
    chunk_left = 0;
    enq_bias = 50;
    focus = 1'b0;
    tie_mode = 1'b0;
    focus_qid = 0;
    unused.status = STAT_OK;
    for (int i = 0; i < n_items; i++) begin
      n_act = eff_active();
      if (chunk_left == 0) begin
        chunk_left = $urandom_range(8, 24);
        case ($urandom_range(0, 3))
          0: enq_bias = 20;
          1: enq_bias = 50;
          2: enq_bias = 80;
          default: enq_bias = 95;
        endcase
        focus = ($urandom_range(0, 3) == 0);
        focus_qid = (n_act > 0) ? $urandom_range(0, n_act - 1) : 0;
        tie_mode = ($urandom_range(0, 3) == 0);
        tx_fast = ($urandom_range(0, 3) == 0);
      end
      // Receiver holds off while the sender keeps offering back to back.
      if (do_hold && i == 20) begin
        long_hold = 1'b1;
        tx_fast = 1'b1;
        chunk_left = 20;
      end
      // Sender pauses until the block has returned everything.
      if (do_pause && i == n_items / 2) drain();
      chunk_left--;

      r.op = ($urandom_range(0, 99) < enq_bias) ? OP_ENQUEUE : OP_DEQUEUE;
      if (n_act == 0 || $urandom_range(0, 9) == 0) r.qid = $urandom_range(0, 7);
      else if (focus) r.qid = focus_qid;
      else r.qid = $urandom_range(0, n_act - 1);
      if (tie_mode) begin
        case ($urandom_range(0, 2))
          0: r.prio = 8'd0;
          1: r.prio = 8'd128;
          default: r.prio = 8'd255;
        endcase
      end else begin
        r.prio = $urandom_range(0, 255);
      end
      case ($urandom_range(0, 15))
        0: r.buf_handle = 32'h0;
        1: r.buf_handle = 32'hFFFF_FFFF;
        default: r.buf_handle = $urandom;
      endcase
      case ($urandom_range(0, 15))
        0: r.nbytes = 16'h0;
        1: r.nbytes = 16'hFFFF;
        default: r.nbytes = $urandom_range(0, 65535);
      endcase
      send_req(r, 1'b0, unused);
    end
  endtask

  // Result receiver: random stalls, stretches without stalls, one long hold.
  initial begin
    int stall;
    int served;
    bit rx_fast;
    served = 0;
    rx_fast = 1'b0;
    wait (rst_n === 1'b1);
    forever begin
      if (served % 16 == 0) rx_fast = ($urandom_range(0, 3) == 0);
      if (long_hold) begin
        stall = HOLD_CYCLES;
        long_hold = 1'b0;
      end else begin
        stall = rx_fast ? 0 : $urandom_range(0, 19);
      end
      if (stall > 0) begin
        out_tready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_tready <= 1'b1;
      do @(posedge clk); while (!out_tvalid);
      served++;
    end
  end

  // Compare every result transaction with the oldest expectation.
  always @(posedge clk) begin : check_result
    sched_res_t want;
    if (rst_n && out_tvalid && out_tready) begin
      if (pending_results.size() == 0) begin
        $error("result transaction with no expectation waiting: 0x%0h", out_tdata);
        fail_count++;
      end else begin
        want = pending_results.pop_front();
        check_field("status", want.status, out_tdata[1:0]);
        check_field("out_priority", want.prio, out_tdata[9:2]);
        check_field("out_handle", want.buf_handle, out_tdata[41:10]);
        check_field("out_size", want.nbytes, out_tdata[57:42]);
        check_field("best_valid", want.best_valid, out_tdata[58]);
        check_field("best_task", want.best_qid, out_tdata[61:59]);
      end
    end
  end

  // Watchdog on cycles without any transaction.
  always @(posedge clk) begin
    if (!rst_n || (in_tvalid && in_tready) || (out_tvalid && out_tready)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("status: fail");
      $finish;
    end
  end

  // Main sequence: reset, directed table, random phases, final check.
  initial begin
    int act_vals [NUM_PHASES];
    int lim_vals [NUM_PHASES];
    int counts [NUM_PHASES];
    act_vals = '{15, 1, 3, 24, 0, 6, 8, 2, 8, 7};
    lim_vals = '{31, 1, 4, 16, 0, 31, 2, 16, 8, 3};
    counts   = '{50, 40, 60, 60, 15, 60, 50, 40, 60, 60};
    rst_n <= 1'b0;
    in_tvalid <= 1'b0;
    in_tdata <= '0;
    in_tuser <= OP_ENQUEUE;
    out_tready <= 1'b0;
    cfg_we <= 1'b0;
    cfg_index <= CFG_ACTIVE;
    cfg_wdata <= '0;
    fail_count = 0;
    tx_fast = 1'b0;
    long_hold = 1'b0;
    for (int q = 0; q < NTASK; q++) begin
      head_ptr[q] = 0;
      fill[q] = 0;
    end
    active_reg = ACTIVE_RST;
    limit_reg = LIMIT_RST;

    // Empty queue after reset, handle zero, field extremes, ties.
    add_typed(OP_DEQUEUE, 3'd0, 8'd0, 32'h0, 16'h0, STAT_EMPTY, 1'b0, 3'd0);
    add_typed(OP_ENQUEUE, 3'd1, 8'd0, 32'h0, 16'h0, STAT_OK, 1'b1, 3'd1);
    add_typed(OP_ENQUEUE, 3'd7, 8'd255, 32'hFFFF_FFFF, 16'hFFFF, STAT_OK, 1'b1, 3'd7);
    add_item(OP_ENQUEUE, 3'd2, 8'd255, 32'hA5A5_A5A5, 16'h5A5A);
    add_item(OP_DEQUEUE, 3'd7, 8'd0, 32'h0, 16'h0);
    add_item(OP_DEQUEUE, 3'd7, 8'd0, 32'h0, 16'h0);
    // A limit equal to the occupancy refuses the enqueue.
    add_cfg(CFG_LIMIT, 5'd1);
    add_typed(OP_ENQUEUE, 3'd1, 8'd9, 32'h1234_5678, 16'h0042, STAT_FULL, 1'b1, 3'd2);
    // Tasks past the active count are out of range; their entries are ignored.
    add_cfg(CFG_ACTIVE, 5'd2);
    add_typed(OP_ENQUEUE, 3'd2, 8'd1, 32'h1, 16'h1, STAT_RANGE, 1'b1, 3'd1);
    add_typed(OP_DEQUEUE, 3'd7, 8'd0, 32'h0, 16'h0, STAT_RANGE, 1'b1, 3'd1);
    // No active task at all.
    add_cfg(CFG_ACTIVE, 5'd0);
    add_typed(OP_ENQUEUE, 3'd0, 8'd5, 32'h5, 16'h5, STAT_RANGE, 1'b0, 3'd0);
    // Register values above the queue set saturate.
    add_cfg(CFG_ACTIVE, 5'd15);
    add_cfg(CFG_LIMIT, 5'd31);
    add_item(OP_ENQUEUE, 3'd7, 8'd10, 32'hDEAD_0001, 16'h0010);
    add_item(OP_DEQUEUE, 3'd1, 8'd0, 32'h0, 16'h0);
    add_item(OP_DEQUEUE, 3'd2, 8'd0, 32'h0, 16'h0);
    add_item(OP_ENQUEUE, 3'd4, 8'd255, 32'h0, 16'h0);
    add_item(OP_ENQUEUE, 3'd3, 8'd255, 32'h8000_0000, 16'h8000);
    add_item(OP_DEQUEUE, 3'd3, 8'd0, 32'h0, 16'h0);
    // A zero limit refuses every enqueue.
    add_cfg(CFG_LIMIT, 5'd0);
    add_item(OP_ENQUEUE, 3'd6, 8'd77, 32'h7777_7777, 16'h7777);
    add_item(OP_DEQUEUE, 3'd4, 8'd0, 32'h0, 16'h0);

    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (dir_rows[i]) begin
      if (dir_rows[i].kind == ROW_CFG) begin
        drain();
        write_reg(dir_rows[i].cfg_idx, dir_rows[i].cfg_val);
      end else begin
        send_req(dir_rows[i].req, dir_rows[i].typed, dir_rows[i].res);
      end
    end

    // Random phases; queue contents carry over from one setting to the next.
    for (int p = 0; p < NUM_PHASES; p++) begin
      drain();
      write_reg(CFG_ACTIVE, act_vals[p][CFG_DATA_W-1:0]);
      write_reg(CFG_LIMIT, lim_vals[p][CFG_DATA_W-1:0]);
      run_phase(counts[p], p == 2, p == 8);
    end

    drain();
    repeat (30) @(posedge clk);
    if (fail_count == 0 && pending_results.size() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule

### multi_queue_priority_select.f
src/mqps_pkg.sv
src/mqps_ram.sv
src/multi_queue_priority_select.sv
verif/tb_multi_queue_priority_select.sv
